// ===== src/bbpp_pkg.sv =====
package bbpp_pkg;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [30:0] particle_radius;
		logic pinned;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] new_x;
		logic signed [31:0] new_y;
		logic signed [31:0] new_z;
		logic moved;
	} out_word_t;

	localparam logic [3:0] REG_MIN_X = 4'd0;
	localparam logic [3:0] REG_MIN_Y = 4'd1;
	localparam logic [3:0] REG_MIN_Z = 4'd2;
	localparam logic [3:0] REG_MAX_X = 4'd3;
	localparam logic [3:0] REG_MAX_Y = 4'd4;
	localparam logic [3:0] REG_MAX_Z = 4'd5;
	localparam logic [3:0] REG_GAIN  = 4'd6;
	localparam logic [3:0] REG_STEP  = 4'd7;

	localparam logic signed [34:0] OUTER_CLAMP = 35'sh07FFFFFFF;
	localparam logic signed [34:0] GRAD_CLAMP  = 35'sd16777216;

endpackage

// ===== src/box_boundary_particle_projection.sv =====
// Box boundary projection: one particle word in and one out per cycle while the output
// is not stalled. The path has four setup stages, a 32-stage root for the seven probe
// distances, four gradient stages, a 32-stage root for the gradient norm, one product
// stage, a 20-stage divider at four quotient bits per stage, and the output register.
// A stall on the output freezes the whole pipeline. The input is stalled only while a
// finished word waits, and the output register holds that word until it is taken.
module box_boundary_particle_projection (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bbpp_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bbpp_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import bbpp_pkg::*;

	localparam int LAT = 94;

	logic signed [31:0] mn_q [3];
	logic signed [31:0] mx_q [3];
	logic [17:0] gain_q;
	logic [15:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				mn_q[i] <= '0;
				mx_q[i] <= 32'sd65536;
			end
			gain_q <= 18'd65536;
			step_q <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X: mn_q[0] <= cfg_data;
				REG_MIN_Y: mn_q[1] <= cfg_data;
				REG_MIN_Z: mn_q[2] <= cfg_data;
				REG_MAX_X: mx_q[0] <= cfg_data;
				REG_MAX_Y: mx_q[1] <= cfg_data;
				REG_MAX_Z: mx_q[2] <= cfg_data;
				REG_GAIN:  gain_q <= cfg_data[17:0];
				REG_STEP:  step_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// valid shift line
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end
	assign out_valid = vld_q[LAT-1];

	// s1: centre, size, q
	in_word_t in_s1;
	logic signed [33:0] q_s1 [3];
	logic signed [33:0] sz_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
			for (int i = 0; i < 3; i++) begin
				logic signed [32:0] sm, c;
				logic signed [33:0] dd;
				logic signed [31:0] pv;
				pv = (i == 0) ? in_data.pos_x : ((i == 1) ? in_data.pos_y : in_data.pos_z);
				sm = 33'(mn_q[i]) + 33'(mx_q[i]);
				c = sm >>> 1;
				dd = 34'(mn_q[i]) - 34'(c);
				sz_s1[i] <= dd < 0 ? -dd : dd;
				q_s1[i] <= 34'(pv) - 34'(c);
			end
		end
	end

	// seven probe points: centre, then -/+ step on each axis
	// s2: e per axis per probe, clamped outer term, inner
	logic signed [34:0] inner_s2 [7];
	logic [30:0] c_s2 [7][3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 7; p++) begin
				logic signed [34:0] e [3];
				logic signed [34:0] mxv, qq;
				for (int i = 0; i < 3; i++) begin
					qq = 35'(q_s1[i]);
					if (p == 2*i+1) qq = qq - 35'(step_q);
					if (p == 2*i+2) qq = qq + 35'(step_q);
					e[i] = (qq < 0 ? -qq : qq) - 35'(sz_s1[i]);
					if (e[i] <= 0) c_s2[p][i] <= '0;
					else if (e[i] > OUTER_CLAMP) c_s2[p][i] <= '1;
					else c_s2[p][i] <= e[i][30:0];
				end
				mxv = e[0];
				if (e[1] > mxv) mxv = e[1];
				if (e[2] > mxv) mxv = e[2];
				inner_s2[p] <= mxv < 0 ? mxv : '0;
			end
		end
	end

	// s3: sum of squares
	logic [63:0] sq_s3 [7];
	logic [63:0] sq_s2b [7][3];
	logic signed [34:0] inner_s3 [7];
	logic signed [34:0] inner_s3b [7];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 7; p++) begin
				for (int i = 0; i < 3; i++) sq_s2b[p][i] <= 64'(c_s2[p][i]) * 64'(c_s2[p][i]);
				inner_s3b[p] <= inner_s2[p];
				sq_s3[p] <= sq_s2b[p][0] + sq_s2b[p][1] + sq_s2b[p][2];
				inner_s3[p] <= inner_s3b[p];
			end
		end
	end

	// delay line for per-item side data through root 1
	localparam int R = 32;
	in_word_t in_d [R+3];
	logic signed [34:0] inner_d [R][7];
	always_ff @(posedge clk) begin
		if (en) begin
			in_d[0] <= in_s1;
			for (int k = 1; k < R + 3; k++) in_d[k] <= in_d[k-1];
			for (int p = 0; p < 7; p++) inner_d[0][p] <= inner_s3[p];
			for (int k = 1; k < R; k++) inner_d[k] <= inner_d[k-1];
		end
	end

	logic [31:0] rt [7];
	genvar gp;
	generate
		for (gp = 0; gp < 7; gp++) begin : g_mag
			bbpp_isqrt u_sq (.clk(clk), .en(en), .rad(sq_s3[gp]), .root(rt[gp]));
		end
	endgenerate

	// in_d[k] lines up with sq_s3 at k=2 and with the roots at k=34 -> in_d[34]
	// inner_d[31] aligns with rt
	logic signed [35:0] m_s4 [7];
	in_word_t in_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int p = 0; p < 7; p++)
				m_s4[p] <= 36'(inner_d[31][p]) + 36'(rt[p]) + 36'(in_d[34].particle_radius);
			in_s4 <= in_d[34];
		end
	end

	// s5: gradient, clamp, squares
	logic signed [34:0] g_s5 [3];
	logic signed [35:0] d_s5;
	in_word_t in_s5;
	logic signed [34:0] g_s6 [3];
	logic [63:0] gsq_s6 [3];
	logic signed [35:0] d_s6;
	in_word_t in_s6;
	logic [63:0] gsum_s7;
	logic signed [34:0] g_s7 [3];
	logic signed [35:0] d_s7;
	in_word_t in_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [36:0] gi;
				gi = (m_s4[2*i+1] > m_s4[2*i+2]) ? 37'(m_s4[2*i+2]) - 37'(m_s4[0])
					: 37'(m_s4[0]) - 37'(m_s4[2*i+1]);
				if (gi > 37'(GRAD_CLAMP)) g_s5[i] <= GRAD_CLAMP;
				else if (gi < -37'(GRAD_CLAMP)) g_s5[i] <= -GRAD_CLAMP;
				else g_s5[i] <= 35'(gi);
			end
			d_s5 <= m_s4[0];
			in_s5 <= in_s4;
			for (int i = 0; i < 3; i++) begin
				gsq_s6[i] <= 64'(g_s5[i]) * 64'(g_s5[i]);
				g_s6[i] <= g_s5[i];
			end
			d_s6 <= d_s5;
			in_s6 <= in_s5;
			gsum_s7 <= gsq_s6[0] + gsq_s6[1] + gsq_s6[2];
			g_s7 <= g_s6;
			d_s7 <= d_s6;
			in_s7 <= in_s6;
		end
	end

	logic [31:0] norm;
	bbpp_isqrt u_norm (.clk(clk), .en(en), .rad(gsum_s7), .root(norm));

	// t computed early, carried alongside norm root
	logic signed [54:0] t_s8;
	logic signed [34:0] g_dl [R][3];
	logic signed [54:0] t_dl [R];
	logic signed [35:0] d_dl [R];
	in_word_t in_dl [R];
	always_ff @(posedge clk) begin
		if (en) begin
			g_dl[0] <= g_s7;
			t_dl[0] <= 55'((55'(gain_q) * 55'(d_s7)) >>> 16) + 55'(
				(d_s7 < 0 && (((55'(gain_q) * 55'(d_s7)) & 55'hFFFF) != 0)) ? 1 : 0);
			d_dl[0] <= d_s7;
			in_dl[0] <= in_s7;
			for (int k = 1; k < R; k++) begin
				g_dl[k] <= g_dl[k-1];
				t_dl[k] <= t_dl[k-1];
				d_dl[k] <= d_dl[k-1];
				in_dl[k] <= in_dl[k-1];
			end
		end
	end
	assign t_s8 = t_dl[R-1];

	// product stage: t*|g| per axis, then divided by norm below
	logic [79:0] num_s9 [3];
	logic [31:0] den_s9;
	logic ok_s9;
	logic [2:0] neg_s9;
	in_word_t in_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				logic [24:0] ag;
				logic [54:0] at;
				ag = g_dl[R-1][i] < 0 ? 25'(-g_dl[R-1][i]) : 25'(g_dl[R-1][i]);
				at = t_s8 < 0 ? 55'(-t_s8) : 55'(t_s8);
				num_s9[i] <= 80'(at) * 80'(ag);
				neg_s9[i] <= (g_dl[R-1][i] < 0) ^ (t_s8 < 0);
			end
			den_s9 <= norm;
			ok_s9 <= (d_dl[R-1] > 0) && !in_dl[R-1].pinned && (norm != 0);
			in_s9 <= in_dl[R-1];
		end
	end

	// restoring divider: 80 quotient bits, 4 per stage over 20 stages
	localparam int DS = 20;
	logic [79:0] qq_d [DS+1][3];
	logic [31:0] rm_d [DS+1][3];
	logic [31:0] dv_d [DS+1];
	logic [79:0] nm_d [DS+1][3];
	logic ok_d [DS+1];
	logic [2:0] ng_d [DS+1];
	in_word_t iw_d [DS+1];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qq_d[0][i] = '0;
			rm_d[0][i] = '0;
			nm_d[0][i] = num_s9[i];
		end
		dv_d[0] = den_s9;
		ok_d[0] = ok_s9;
		ng_d[0] = neg_s9;
		iw_d[0] = in_s9;
	end
	genvar gs;
	generate
		for (gs = 0; gs < DS; gs++) begin : g_div
			always_ff @(posedge clk) begin
				if (en) begin
					for (int i = 0; i < 3; i++) begin
						logic [32:0] r;
						logic [79:0] qv, nv;
						r = 33'(rm_d[gs][i]);
						qv = qq_d[gs][i];
						nv = nm_d[gs][i];
						for (int b = 0; b < 4; b++) begin
							r = {r[31:0], nv[79]};
							nv = nv << 1;
							qv = qv << 1;
							if (r >= 33'(dv_d[gs])) begin
								r = r - 33'(dv_d[gs]);
								qv[0] = 1'b1;
							end
						end
						rm_d[gs+1][i] <= r[31:0];
						qq_d[gs+1][i] <= qv;
						nm_d[gs+1][i] <= nv;
					end
					dv_d[gs+1] <= dv_d[gs];
					ok_d[gs+1] <= ok_d[gs];
					ng_d[gs+1] <= ng_d[gs];
					iw_d[gs+1] <= iw_d[gs];
				end
			end
		end
	endgenerate

	// final: apply and saturate into the output register
	out_word_t res;
	always_comb begin
		logic signed [81:0] nv [3];
		logic signed [31:0] p [3];
		p[0] = iw_d[DS].pos_x;
		p[1] = iw_d[DS].pos_y;
		p[2] = iw_d[DS].pos_z;
		for (int i = 0; i < 3; i++) begin
			nv[i] = ng_d[DS][i] ? 82'(p[i]) + 82'(qq_d[DS][i])
				: 82'(p[i]) - 82'(qq_d[DS][i]);
			if (!ok_d[DS]) nv[i] = 82'(p[i]);
			else if (nv[i] > 82'sd2147483647) nv[i] = 82'sd2147483647;
			else if (nv[i] < -82'sd2147483648) nv[i] = -82'sd2147483648;
		end
		res.new_x = nv[0][31:0];
		res.new_y = nv[1][31:0];
		res.new_z = nv[2][31:0];
		res.moved = ok_d[DS];
	end

	always_ff @(posedge clk) begin
		if (en) out_data <= res;
	end

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("word dropped under stall");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data)) else $error("held word changed");
	a_known_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data)) else $error("unknown output word");
	a_stall_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall) else $error("stall without backpressure");
	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(vld_q)) else $error("pipeline moved under stall");
endmodule

// ===== src/bbpp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module bbpp_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	logic [63:0] rem_q [0:32];
	logic [31:0] res_q [0:32];
	logic [63:0] trial [0:31];
	logic [31:0] cand [0:31];

	always_comb begin
		rem_q[0] = rad;
		res_q[0] = '0;
	end

	genvar k;
	generate
		for (k = 0; k < 32; k++) begin : g_bit
			logic [63:0] rem_s;
			logic [31:0] res_s;
			always_comb begin
				cand[k] = res_q[k] | (32'd1 << (31 - k));
				trial[k] = 64'(cand[k]) * 64'(cand[k]);
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s <= rem_q[k];
					res_s <= (trial[k] <= rem_q[k]) ? cand[k] : res_q[k];
				end
			end
			assign rem_q[k+1] = rem_s;
			assign res_q[k+1] = res_s;
		end
	endgenerate

	assign root = res_q[32];
endmodule

// ===== tb/bbpp_checker.sv =====
`timescale 1ns / 100ps

module bbpp_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  bbpp_pkg::in_word_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  bbpp_pkg::out_word_t out_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output int                  fail_count,
	output int                  pending
);
	import bbpp_pkg::*;

	typedef longint vec3_t [3];

	logic [31:0] box_lo [3];
	logic [31:0] box_hi [3];
	logic [17:0] gain;
	logic [15:0] step;

	out_word_t projected_q [$];

	function automatic longint abs64(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint unsigned root64(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// signed distance to the box surface plus radius
	function automatic longint box_dist(vec3_t q, vec3_t s, longint rad);
		longint e [3];
		longint mx, inner, c;
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < 3; i++) e[i] = abs64(q[i]) - s[i];
		mx = e[0];
		if (e[1] > mx) mx = e[1];
		if (e[2] > mx) mx = e[2];
		inner = (mx < 0) ? mx : 0;
		for (int i = 0; i < 3; i++) begin
			c = (e[i] > 0) ? e[i] : 0;
			if (c > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
			acc = acc + longint'(c * c);
		end
		return inner + longint'(root64(acc)) + rad;
	endfunction

	function automatic out_word_t project(in_word_t w);
		out_word_t r;
		vec3_t q, s, p;
		longint pos [3];
		longint g [3];
		longint lo, sum, c, rad, d, m0, m1, gi, norm, t, dm, nv;
		longint unsigned gsum;
		gsum = 0;
		pos[0] = longint'(w.pos_x);
		pos[1] = longint'(w.pos_y);
		pos[2] = longint'(w.pos_z);
		rad = longint'({33'd0, w.particle_radius});
		for (int i = 0; i < 3; i++) begin
			lo = longint'($signed(box_lo[i]));
			sum = lo + longint'($signed(box_hi[i]));
			c = (sum >= 0) ? sum / 2 : -((-sum + 1) / 2);
			s[i] = abs64(lo - c);
			q[i] = pos[i] - c;
		end
		r.new_x = w.pos_x;
		r.new_y = w.pos_y;
		r.new_z = w.pos_z;
		r.moved = 1'b0;
		d = box_dist(q, s, rad);
		if (d <= 0 || w.pinned) return r;
		for (int i = 0; i < 3; i++) begin
			p = q;
			p[i] = q[i] - longint'(step);
			m0 = box_dist(p, s, rad);
			p[i] = q[i] + longint'(step);
			m1 = box_dist(p, s, rad);
			gi = (m0 > m1) ? (m1 - d) : (d - m0);
			if (gi > 16777216) gi = 16777216;
			if (gi < -16777216) gi = -16777216;
			g[i] = gi;
			gsum = gsum + longint'(gi * gi);
		end
		norm = longint'(root64(gsum));
		if (norm == 0) return r;
		t = (longint'(gain) * d) / 65536;
		for (int i = 0; i < 3; i++) begin
			dm = (t * abs64(g[i])) / norm;
			nv = pos[i] - ((g[i] < 0) ? -dm : dm);
			if (nv > 64'sd2147483647) nv = 64'sd2147483647;
			if (nv < -64'sd2147483648) nv = -64'sd2147483648;
			case (i)
				0: r.new_x = nv[31:0];
				1: r.new_y = nv[31:0];
				default: r.new_z = nv[31:0];
			endcase
		end
		r.moved = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_lo[i] <= 32'd0;
				box_hi[i] <= 32'd65536;
			end
			gain <= 18'd65536;
			step <= 16'd6554;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN_X: box_lo[0] <= cfg_data;
				REG_MIN_Y: box_lo[1] <= cfg_data;
				REG_MIN_Z: box_lo[2] <= cfg_data;
				REG_MAX_X: box_hi[0] <= cfg_data;
				REG_MAX_Y: box_hi[1] <= cfg_data;
				REG_MAX_Z: box_hi[2] <= cfg_data;
				REG_GAIN:  gain <= cfg_data[17:0];
				REG_STEP:  step <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	initial begin
		fail_count = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n) begin
			if (in_valid && !in_stall) projected_q = {projected_q, project(in_data)};
			if (out_valid && !out_stall) begin
				if (projected_q.size() == 0) begin
					$error("unexpected output word %h", out_data);
					fail_count++;
				end else begin
					exp_w = projected_q.pop_front();
					if (out_data.new_x !== exp_w.new_x) begin
						$error("new_x expected %0d got %0d", exp_w.new_x, out_data.new_x);
						fail_count++;
					end
					if (out_data.new_y !== exp_w.new_y) begin
						$error("new_y expected %0d got %0d", exp_w.new_y, out_data.new_y);
						fail_count++;
					end
					if (out_data.new_z !== exp_w.new_z) begin
						$error("new_z expected %0d got %0d", exp_w.new_z, out_data.new_z);
						fail_count++;
					end
					if (out_data.moved !== exp_w.moved) begin
						$error("moved expected %0d got %0d", exp_w.moved, out_data.moved);
						fail_count++;
					end
				end
			end
			pending = projected_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import bbpp_pkg::*;

	localparam logic [3:0] REG_UNUSED = 4'd9;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_word_t out_data;
	logic      cfg_we;
	logic [3:0]  cfg_index;
	logic [31:0] cfg_data;
	int        fail_count;
	int        pending;

	int        send_idle;
	int        recv_idle;
	int        hold_cnt;
	longint    cur_lo [3];
	longint    cur_hi [3];

	box_boundary_particle_projection u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bbpp_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver side: long hold-offs are counted here
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt = hold_cnt - 1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle);
			end
		end
	end

	function automatic logic [31:0] sat32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic in_word_t make_particle();
		in_word_t w;
		longint span, lo, pv [3];
		if ($urandom_range(99) < 25) begin
			w.pos_x = $urandom;
			w.pos_y = $urandom;
			w.pos_z = $urandom;
			w.particle_radius = 31'($urandom);
			w.pinned = 1'($urandom_range(1));
			return w;
		end
		for (int i = 0; i < 3; i++) begin
			lo = (cur_lo[i] < cur_hi[i]) ? cur_lo[i] : cur_hi[i];
			span = cur_hi[i] - cur_lo[i];
			if (span < 0) span = -span;
			if (span > 64'd1 << 29) span = 64'd1 << 29;
			if (span < 4096) span = 4096;
			pv[i] = lo + longint'($urandom_range(3 * span)) - span;
		end
		w.pos_x = sat32(pv[0]);
		w.pos_y = sat32(pv[1]);
		w.pos_z = sat32(pv[2]);
		w.particle_radius = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(65536));
		w.pinned = ($urandom_range(9) == 0);
		return w;
	endfunction

	task automatic send_word(in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_box(logic [31:0] lx, logic [31:0] ly, logic [31:0] lz,
			logic [31:0] hx, logic [31:0] hy, logic [31:0] hz);
		write_reg(REG_MIN_X, lx);
		write_reg(REG_MIN_Y, ly);
		write_reg(REG_MIN_Z, lz);
		write_reg(REG_MAX_X, hx);
		write_reg(REG_MAX_Y, hy);
		write_reg(REG_MAX_Z, hz);
		cur_lo[0] = longint'($signed(lx));
		cur_lo[1] = longint'($signed(ly));
		cur_lo[2] = longint'($signed(lz));
		cur_hi[0] = longint'($signed(hx));
		cur_hi[1] = longint'($signed(hy));
		cur_hi[2] = longint'($signed(hz));
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [31:0] rnd_corner();
		return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
	endfunction

	initial begin
		in_word_t w;
		logic signed [31:0] dir_pos [12];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 22;
		recv_idle = 69;
		hold_cnt = 0;
		for (int i = 0; i < 3; i++) begin
			cur_lo[i] = 0;
			cur_hi[i] = 65536;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset box [0,1]^3, inside, outside on every face but the lower z face, extremes
		dir_pos = '{32'sd32768, 32'sd0, 32'sd65536, -32'sd65536, 32'sd131072, 32'sd98304,
			32'sh7FFFFFFF, 32'sh80000000, -32'sd1, 32'sd65537, 32'sd16384, 32'sd200000};
		for (int k = 0; k < 12; k++) begin
			w.pos_x = dir_pos[k];
			w.pos_y = (k % 3 == 0) ? dir_pos[k] : 32'sd32768;
			w.pos_z = (k % 4 == 1) ? dir_pos[11 - k] : 32'sd32768;
			w.particle_radius = (k == 6) ? 31'h7FFFFFFF : ((k < 2) ? 31'd0 : 31'd3000);
			w.pinned = 1'b0;
			send_word(w);
		end
		// pinned outside, pinned inside, radius only pushes inside particle out
		w = '{pos_x: 32'sd200000, pos_y: 32'sd32768, pos_z: 32'sd32768,
			particle_radius: 31'd100, pinned: 1'b1};
		send_word(w);
		w.pos_x = 32'sd32768;
		send_word(w);
		w.pinned = 1'b0;
		w.particle_radius = 31'd40000;
		send_word(w);
		w = '{pos_x: 32'sh80000000, pos_y: 32'sh80000000, pos_z: 32'sh7FFFFFFF,
			particle_radius: 31'h7FFFFFFF, pinned: 1'b0};
		send_word(w);
		drain();

		// unknown index must be ignored, then a zero probe step gives no move
		write_reg(REG_UNUSED, 32'hDEAD_BEEF);
		write_reg(REG_STEP, 32'd0);
		for (int k = 0; k < 4; k++) begin
			w = make_particle();
			w.pos_x = 32'sd300000 + 32'(k);
			w.pinned = 1'b0;
			send_word(w);
		end
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle = 69;
				recv_idle = 22;
			end else if (ph == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			case (ph)
				0: begin
					set_box(-32'sd65536, -32'sd65536, -32'sd131072,
						32'sd131072, 32'sd65536, 32'sd65536);
					write_reg(REG_GAIN, 32'd65536);
					write_reg(REG_STEP, 32'd6554);
				end
				1: begin
					set_box(rnd_corner(), rnd_corner(), rnd_corner(),
						rnd_corner(), rnd_corner(), rnd_corner());
					write_reg(REG_GAIN, $urandom_range(131072));
					write_reg(REG_STEP, $urandom_range(65535, 1));
				end
				2: begin
					// full-range x, inverted y
					set_box(32'h80000000, 32'sd262144, 32'sd0,
						32'h7FFFFFFF, -32'sd65536, 32'sd1);
					write_reg(REG_GAIN, 32'd131072);
					write_reg(REG_STEP, 32'd65535);
				end
				3: begin
					set_box(rnd_corner(), rnd_corner(), rnd_corner(),
						rnd_corner(), rnd_corner(), rnd_corner());
					write_reg(REG_GAIN, 32'd0);
					write_reg(REG_STEP, 32'd1);
				end
				4: begin
					set_box(32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
					// gain beyond nominal range, junk above the register width
					write_reg(REG_GAIN, 32'hFFFF_FFFF);
					write_reg(REG_STEP, 32'hABCD_0100);
				end
				default: begin
					set_box(rnd_corner(), rnd_corner(), rnd_corner(),
						rnd_corner(), rnd_corner(), rnd_corner());
					write_reg(REG_GAIN, $urandom_range(131072));
					write_reg(REG_STEP, $urandom_range(65535, 1));
				end
			endcase
			for (int n = 0; n < 305; n++) begin
				if (ph == 1 && n == 150) hold_cnt = 400;
				if (ph == 3 && n == 150) begin
					@(negedge clk);
					in_valid <= 1'b0;
					wait (pending == 0);
				end
				send_word(make_particle());
			end
			drain();
		end

		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
